[hw/rtl/sca_pkg.sv]
// Shared types and constants for the slab class allocator.
package sca_pkg;

  localparam int NUM_CLASSES_DEF     = 16;
  localparam int SLOTS_PER_CLASS_DEF = 1024;

  localparam int CLS_W   = 4;
  localparam int SIZE_W  = 16;
  localparam int SLOT_W  = 10;
  localparam int USED_W  = 25;
  localparam int BYTES_W = 16;
  localparam int LOG2_W  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD  = 2'd2;

  localparam logic [LOG2_W-1:0] MIN_LOG2_RST = 4'd5;
  localparam logic [LOG2_W-1:0] MAX_LOG2_RST = 4'd14;
  localparam logic [CLS_W-1:0]  PRELOAD_RST  = 4'd1;

  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [CLS_W-1:0]  free_class;
    logic [SLOT_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [CLS_W-1:0]  class_id;
    logic [SLOT_W-1:0] slot_index;
    logic [USED_W-1:0] bytes_used;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

[hw/rtl/slab_class_allocator.sv]
// Slab class allocator: power-of-two size classes with per-class LIFO free stacks.
// Flow: a word is accepted only while idle, and no new word is taken until it is committed;
//   the stack memory is read in the accept cycle, and the stack, counters and result register
//   are updated at commit, which waits while a held result is stalled on the output.
// Reset: the preload class reads as full through a low-water mark, so no clearing
//   pass runs and words are taken from the first cycle after reset.
module slab_class_allocator #(
  parameter int NUM_CLASSES     = sca_pkg::NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = sca_pkg::SLOTS_PER_CLASS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sca_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sca_pkg::rsp_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sca_pkg::cmd_t cmd;

  sca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sca_dpath #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted word did not hold off the next one");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no word in flight");

  a_fail_has_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != sca_pkg::ST_OK) |-> (out_data_o.slot_index == '0))
    else $error("failed request returned a slot");

  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> !cmd.commit)
    else $error("one word committed twice");

endmodule

[hw/rtl/sca_ctrl.sv]
// Request sequencer for the slab class allocator.
module sca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sca_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   commit;

  assign commit         = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit   = commit;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= commit || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/sca_dpath.sv]
// Class mapping, free stacks, counters and result register of the slab class allocator.
module sca_dpath #(
  parameter int NUM_CLASSES     = sca_pkg::NUM_CLASSES_DEF,
  parameter int SLOTS_PER_CLASS = sca_pkg::SLOTS_PER_CLASS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sca_pkg::cmd_t                  cmd_i,
  input  sca_pkg::req_t                  in_data_i,
  input  logic                           cfg_we_i,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sca_pkg::rsp_t                  out_data_o
);

  localparam int CIDX_W = $clog2(NUM_CLASSES);
  localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);
  localparam int POS_W  = $clog2(SLOTS_PER_CLASS);
  localparam int DEPTH  = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS_PER_CLASS);
  localparam logic [4:0]       NC_5     = 5'(NUM_CLASSES);

  function automatic logic [4:0] ceil_log2(input logic [sca_pkg::SIZE_W-1:0] s);
    logic [sca_pkg::SIZE_W-1:0] m;
    logic [4:0]                 r;
    m = s - 16'd1;
    r = '0;
    for (int i = 0; i < sca_pkg::SIZE_W; i++) begin
      if (m[i]) r = 5'(i + 1);
    end
    return r;
  endfunction

  // configuration
  logic [sca_pkg::LOG2_W-1:0] min_q, max_q;
  logic [sca_pkg::CLS_W-1:0]  preload_q;

  // per-class counts, low-water mark and byte count
  logic [CNT_W-1:0]           count_q [NUM_CLASSES];
  logic [CNT_W-1:0]           low_q;
  logic [sca_pkg::USED_W-1:0] used_q;

  // stack memory
  logic [sca_pkg::SLOT_W-1:0] mem [DEPTH];
  logic [sca_pkg::SLOT_W-1:0] rdata_q;

  // request captured at accept
  logic                        type_q;
  sca_pkg::status_e            st_q;
  logic [sca_pkg::CLS_W-1:0]   cls_q;
  logic [POS_W-1:0]            pos_q;
  logic [ADDR_W-1:0]           addr_q;
  logic [sca_pkg::SLOT_W-1:0]  fslot_q;
  logic [sca_pkg::BYTES_W-1:0] bytes_q;

  sca_pkg::rsp_t out_q;

  // capture-side logic
  logic [4:0]                  e_log2, c_raw, min_5, max_5;
  logic                        alloc_found, free_ok, cls_ok, is_free;
  logic [sca_pkg::CLS_W-1:0]   sel_cls;
  logic [CNT_W-1:0]            cnt;
  sca_pkg::status_e            st_d;
  logic [POS_W-1:0]            pos_d;
  logic [ADDR_W-1:0]           addr_d;
  logic [sca_pkg::LOG2_W-1:0]  shamt;
  logic [sca_pkg::BYTES_W-1:0] bytes_d;
  logic                        mem_re;

  // commit-side logic
  logic                         ok_q;
  logic [CIDX_W-1:0]            cidx_q;
  logic                         bypass;
  logic [sca_pkg::SLOT_W-1:0]   slot_d;
  logic [sca_pkg::USED_W:0]     sum;
  logic [sca_pkg::USED_W-1:0]   used_d;
  logic                         mem_we;

  assign is_free = (in_data_i.req_type == sca_pkg::REQ_FREE);
  assign min_5   = {1'b0, min_q};
  assign max_5   = {1'b0, max_q};
  assign e_log2  = ceil_log2(in_data_i.req_size);
  assign c_raw   = (e_log2 > min_5) ? e_log2 - min_5 : 5'd0;

  assign alloc_found = (in_data_i.req_size != '0) && (c_raw < NC_5) &&
                       (min_5 + c_raw <= max_5);
  assign free_ok     = ({1'b0, in_data_i.free_class} < NC_5) &&
                       (min_5 + {1'b0, in_data_i.free_class} <= max_5);

  always_comb begin
    if (is_free) begin
      sel_cls = in_data_i.free_class;
      cls_ok  = free_ok;
    end else begin
      sel_cls = alloc_found ? c_raw[sca_pkg::CLS_W-1:0] : '0;
      cls_ok  = alloc_found;
    end
    cnt = cls_ok ? count_q[sel_cls[CIDX_W-1:0]] : '0;
    if (!cls_ok) begin
      st_d = sca_pkg::ST_BAD_SIZE;
    end else if (is_free) begin
      st_d = (cnt == CNT_FULL) ? sca_pkg::ST_FULL : sca_pkg::ST_OK;
    end else begin
      st_d = (cnt == '0) ? sca_pkg::ST_EMPTY : sca_pkg::ST_OK;
    end
    if (is_free) begin
      pos_d = cnt[POS_W-1:0];
    end else begin
      pos_d = POS_W'(cnt - CNT_W'(1));
    end
    addr_d  = ADDR_W'(sel_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(pos_d);
    shamt   = min_q + sel_cls;
    bytes_d = sca_pkg::BYTES_W'(1) << shamt;
  end

  assign mem_re = cmd_i.capture && !is_free && (st_d == sca_pkg::ST_OK);

  // commit: slots of the preload class below the low-water mark still hold their index
  assign ok_q   = (st_q == sca_pkg::ST_OK);
  assign cidx_q = cls_q[CIDX_W-1:0];
  assign bypass = (cls_q == preload_q) && (CNT_W'(pos_q) < low_q);
  assign mem_we = cmd_i.commit && ok_q && (type_q == sca_pkg::REQ_FREE);

  always_comb begin
    sum    = {1'b0, used_q} + (sca_pkg::USED_W + 1)'(bytes_q);
    used_d = used_q;
    slot_d = '0;
    if (ok_q) begin
      if (type_q == sca_pkg::REQ_FREE) begin
        used_d = (used_q > sca_pkg::USED_W'(bytes_q)) ?
                 used_q - sca_pkg::USED_W'(bytes_q) : '0;
      end else begin
        used_d = (sum > {1'b0, sca_pkg::USED_MAX}) ?
                 sca_pkg::USED_MAX : sum[sca_pkg::USED_W-1:0];
        slot_d = bypass ? sca_pkg::SLOT_W'(pos_q) : rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= sca_pkg::MIN_LOG2_RST;
      max_q     <= sca_pkg::MAX_LOG2_RST;
      preload_q <= sca_pkg::PRELOAD_RST;
      low_q     <= CNT_FULL;
      used_q    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        count_q[i] <= (i == int'(sca_pkg::PRELOAD_RST)) ? CNT_FULL : '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sca_pkg::CFG_MIN_LOG2: min_q <= cfg_data_i;
        sca_pkg::CFG_MAX_LOG2: max_q <= cfg_data_i;
        sca_pkg::CFG_PRELOAD: begin
          preload_q <= cfg_data_i;
          low_q     <= CNT_FULL;
          used_q    <= '0;
          for (int i = 0; i < NUM_CLASSES; i++) begin
            count_q[i] <= (5'(i) == {1'b0, cfg_data_i}) ? CNT_FULL : '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.commit && ok_q) begin
      used_q <= used_d;
      if (type_q == sca_pkg::REQ_FREE) begin
        count_q[cidx_q] <= count_q[cidx_q] + CNT_W'(1);
      end else begin
        count_q[cidx_q] <= count_q[cidx_q] - CNT_W'(1);
        if (bypass) low_q <= CNT_W'(pos_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= fslot_q;
    if (mem_re) rdata_q <= mem[addr_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q  <= in_data_i.req_type;
      st_q    <= st_d;
      cls_q   <= sel_cls;
      pos_q   <= pos_d;
      addr_q  <= addr_d;
      fslot_q <= in_data_i.free_slot;
      bytes_q <= bytes_d;
    end
    if (cmd_i.commit) begin
      out_q.status     <= st_q;
      out_q.class_id   <= cls_q;
      out_q.slot_index <= slot_d;
      out_q.bytes_used <= used_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[verif/slab_class_allocator_test.sv]
// Self-checking testbench for the slab class allocator: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module slab_class_allocator_test;
  import sca_pkg::*;

  localparam int NCLS         = NUM_CLASSES_DEF;
  localparam int NSLOT        = SLOTS_PER_CLASS_DEF;
  localparam int USED_TOP     = 2**USED_W - 1;
  localparam int WATCHDOG_MAX = 2000;
  localparam int N_DIR        = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t want;
  } dir_row_t;

  typedef struct {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } held_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{REQ_ALLOC, 16'd0,     4'd0,  10'd0},     1'b1, '{ST_BAD_SIZE, 4'd0,  10'd0,    25'd0}},
    '{'{REQ_ALLOC, 16'hFFFF,  4'hF,  10'h3FF},   1'b1, '{ST_BAD_SIZE, 4'd0,  10'd0,    25'd0}},
    '{'{REQ_ALLOC, 16'd1,     4'd0,  10'd0},     1'b1, '{ST_EMPTY,    4'd0,  10'd0,    25'd0}},
    '{'{REQ_ALLOC, 16'd64,    4'd0,  10'd0},     1'b1, '{ST_OK,       4'd1,  10'd1023, 25'd64}},
    '{'{REQ_ALLOC, 16'd33,    4'd0,  10'd0},     1'b1, '{ST_OK,       4'd1,  10'd1022, 25'd128}},
    '{'{REQ_FREE,  16'd0,     4'd1,  10'd1023},  1'b1, '{ST_OK,       4'd1,  10'd0,    25'd64}},
    '{'{REQ_FREE,  16'd0,     4'd1,  10'd0},     1'b1, '{ST_OK,       4'd1,  10'd0,    25'd0}},
    '{'{REQ_FREE,  16'd0,     4'd1,  10'd1023},  1'b1, '{ST_FULL,     4'd1,  10'd0,    25'd0}},
    '{'{REQ_FREE,  16'hFFFF,  4'd15, 10'd0},     1'b1, '{ST_BAD_SIZE, 4'd15, 10'd0,    25'd0}},
    '{'{REQ_FREE,  16'd0,     4'd10, 10'h155},   1'b1, '{ST_BAD_SIZE, 4'd10, 10'd0,    25'd0}},
    '{'{REQ_FREE,  16'd0,     4'd9,  10'd1023},  1'b1, '{ST_OK,       4'd9,  10'd0,    25'd0}},
    '{'{REQ_ALLOC, 16'd16384, 4'd0,  10'd0},     1'b1, '{ST_OK,       4'd9,  10'd1023, 25'd16384}},
    '{'{REQ_ALLOC, 16'd16385, 4'd0,  10'd0},     1'b1, '{ST_BAD_SIZE, 4'd0,  10'd0,    25'd16384}},
    '{'{REQ_ALLOC, 16'd16384, 4'd0,  10'd0},     1'b1, '{ST_EMPTY,    4'd9,  10'd0,    25'd16384}},
    '{'{REQ_ALLOC, 16'd64,    4'd0,  10'd0},     1'b1, '{ST_OK,       4'd1,  10'd0,    25'd16448}},
    '{'{REQ_FREE,  16'd0,     4'd0,  10'h2AA},   1'b1, '{ST_OK,       4'd0,  10'd0,    25'd16416}},
    '{'{REQ_ALLOC, 16'd32,    4'd0,  10'd0},     1'b1, '{ST_OK,       4'd0,  10'h2AA,  25'd16448}},
    '{'{REQ_FREE,  16'd0,     4'd1,  10'd0},     1'b1, '{ST_OK,       4'd1,  10'd0,    25'd16384}},
    '{'{REQ_ALLOC, 16'h8000,  4'd0,  10'd0},     1'b1, '{ST_BAD_SIZE, 4'd0,  10'd0,    25'd16384}},
    '{'{REQ_ALLOC, 16'h1F00,  4'd0,  10'd0},     1'b0, '{ST_OK,       4'd0,  10'd0,    25'd0}},
    '{'{REQ_FREE,  16'hFFFF,  4'd3,  10'h155},   1'b0, '{ST_OK,       4'd0,  10'd0,    25'd0}}
  };

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  req_t                  in_word  = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_MIN_LOG2;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  rsp_t                  out_word;

  logic [SLOT_W-1:0] slab [NCLS][NSLOT];
  int                fill [NCLS];
  int                in_use;
  logic [LOG2_W-1:0] min_log2 = MIN_LOG2_RST;
  logic [LOG2_W-1:0] max_log2 = MAX_LOG2_RST;
  logic [CLS_W-1:0]  pre_cls  = PRELOAD_RST;

  rsp_t  due_rsp [$];
  held_t live_q  [$];
  int    err_cnt   = 0;
  int    rsp_seen  = 0;
  int    hold_left = 0;
  int    idle_cyc  = 0;
  bit    long_done = 1'b0;
  bit    quiet     = 1'b0;

  slab_class_allocator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit class_live(int c);
    return c < NCLS && int'(min_log2) + c <= int'(max_log2);
  endfunction

  function automatic void refill();
    foreach (slab[c, k]) slab[c][k] = '0;
    foreach (fill[c]) fill[c] = 0;
    in_use = 0;
    for (int k = 0; k < NSLOT; k++) slab[pre_cls][k] = SLOT_W'(k);
    fill[pre_cls] = NSLOT;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    int   c;
    int   b;
    bit   found;
    o = '0;
    found = 1'b0;
    if (r.req_type == REQ_ALLOC) begin
      if (r.req_size != 0) begin
        for (c = 0; c < NCLS; c++) begin
          if (!class_live(c)) break;
          if ((1 << (int'(min_log2) + c)) >= int'(r.req_size)) begin
            found = 1'b1;
            break;
          end
        end
      end
      if (!found) begin
        o.status = ST_BAD_SIZE;
      end else begin
        o.class_id = CLS_W'(c);
        if (fill[c] == 0) begin
          o.status = ST_EMPTY;
        end else begin
          b = 1 << (int'(min_log2) + c);
          fill[c]--;
          o.slot_index = slab[c][fill[c]];
          in_use = (in_use > USED_TOP - b) ? USED_TOP : in_use + b;
        end
      end
    end else begin
      c = int'(r.free_class);
      o.class_id = r.free_class;
      if (!class_live(c)) begin
        o.status = ST_BAD_SIZE;
      end else if (fill[c] >= NSLOT) begin
        o.status = ST_FULL;
      end else begin
        b = 1 << (int'(min_log2) + c);
        slab[c][fill[c]] = r.free_slot;
        fill[c]++;
        in_use = (in_use > b) ? in_use - b : 0;
      end
    end
    o.bytes_used = USED_W'(in_use);
    return o;
  endfunction

  function automatic req_t pick_request(int alloc_pct);
    req_t        r;
    logic [31:0] rnd;
    int          e;
    int          k;
    rnd = $urandom;
    r = rnd[$bits(req_t)-1:0];
    if ($urandom_range(0, 99) < 10) return r;
    if (live_q.size() != 0 && $urandom_range(0, 99) >= alloc_pct) begin
      k = $urandom_range(0, live_q.size() - 1);
      r.req_type   = REQ_FREE;
      r.free_class = live_q[k].cls;
      r.free_slot  = live_q[k].slot;
      live_q.delete(k);
      return r;
    end
    r.req_type = REQ_ALLOC;
    case ($urandom_range(0, 4))
      0, 1: begin
        e = int'(min_log2) + int'(pre_cls);
      end
      2, 3: begin
        e = $urandom_range(min_log2, max_log2);
      end
      default: begin
        e = $urandom_range(0, 16);
      end
    endcase
    if (e > 16) e = 16;
    if (e == 0) r.req_size = 16'd1;
    else r.req_size = 16'($urandom_range((1 << e) / 2 + 1, (e == 16) ? 65535 : (1 << e)));
    return r;
  endfunction

  task automatic offer_word(input req_t r, input logic fixed, input rsp_t fixed_rsp);
    rsp_t got;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= r;
    do @(posedge clk); while (in_stall);
    got = serve_request(r);
    due_rsp.push_back(fixed ? fixed_rsp : got);
    if (r.req_type == REQ_ALLOC && got.status == ST_OK)
      live_q.push_back('{got.class_id, got.slot_index});
  endtask

  task automatic run_random(input int n, input int alloc_pct);
    repeat (n) offer_word(pick_request(alloc_pct), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MIN_LOG2: begin
        min_log2 = val;
      end
      CFG_MAX_LOG2: begin
        max_log2 = val;
      end
      CFG_PRELOAD: begin
        pre_cls = val;
        refill();
        live_q.delete();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!long_done && rsp_seen >= 600) begin
      long_done = 1'b1;
      hold_left = 400;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      hold_left = $urandom_range(1, 12);
    end
    out_stall <= (hold_left != 0);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      rsp_seen++;
      if (due_rsp.size() == 0) begin
        $error("unexpected word: status %0d class %0d slot %0d bytes %0d",
               out_word.status, out_word.class_id, out_word.slot_index, out_word.bytes_used);
        err_cnt++;
      end else begin
        want = due_rsp.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          err_cnt++;
        end
        if (out_word.class_id !== want.class_id) begin
          $error("class_id: expected %0d, got %0d", want.class_id, out_word.class_id);
          err_cnt++;
        end
        if (out_word.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_word.slot_index);
          err_cnt++;
        end
        if (out_word.bytes_used !== want.bytes_used) begin
          $error("bytes_used: expected %0d, got %0d", want.bytes_used, out_word.bytes_used);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    req_t        r;
    logic [31:0] rnd;
    refill();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) offer_word(DIR_TAB[i].req, DIR_TAB[i].fixed, DIR_TAB[i].want);
    run_random(250, 60);

    drain();
    set_reg(CFG_MIN_LOG2, 4'd0);
    set_reg(CFG_MAX_LOG2, 4'd15);
    set_reg(CFG_PRELOAD, 4'd0);
    run_random(250, 55);

    // drive the byte count into saturation with the largest class
    drain();
    set_reg(CFG_MIN_LOG2, 4'd15);
    set_reg(CFG_PRELOAD, 4'd0);
    repeat (NSLOT + 6) begin
      rnd = $urandom;
      r = rnd[$bits(req_t)-1:0];
      r.req_type = REQ_ALLOC;
      r.req_size = 16'($urandom_range(16385, 32768));
      offer_word(r, 1'b0, '0);
    end
    run_random(100, 30);

    drain();
    set_reg(CFG_MAX_LOG2, 4'd0);
    set_reg(CFG_SPARE, 4'hF);
    run_random(40, 50);

    drain();
    set_reg(CFG_MIN_LOG2, 4'd0);
    set_reg(CFG_MAX_LOG2, 4'd15);
    set_reg(CFG_PRELOAD, 4'd15);
    run_random(200, 55);

    drain();
    quiet = 1'b1;
    set_reg(CFG_MIN_LOG2, 4'd3);
    set_reg(CFG_MAX_LOG2, 4'd12);
    set_reg(CFG_PRELOAD, 4'd7);
    run_random(150, 55);

    drain();
    repeat (6) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
